// File: rtl/hrt_pkg.sv
// Shared types and constants for the HTTP request head tokenizer.
// Holds the result record, field tags, status codes and character codes.
// No dependencies.
package hrt_pkg;

   typedef enum logic [2:0] {
      TAG_NONE    = 3'd0,
      TAG_METHOD  = 3'd1,
      TAG_URI     = 3'd2,
      TAG_VERSION = 3'd3,
      TAG_KEY     = 3'd4,
      TAG_VALUE   = 3'd5
   } tag_type;

   typedef enum logic [1:0] {
      ST_PARSING  = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_ERROR    = 2'd2
   } status_type;

   typedef struct packed {
      tag_type    field_tag;
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic [7:0] header_index;
      status_type status;
      logic       result_last;
   } rsp_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [3:0] VERSION_BYTES = 4'd8;
   localparam logic [3:0] VLEN_MAX      = 4'd15;
   localparam logic [7:0] HCNT_MAX      = 8'd255;

   localparam int RSP_DEPTH = 4;

endpackage

// File: rtl/hrt_step.sv
// Per-byte tokenizer logic and parse state for the HTTP request head tokenizer.
// Produces up to two result records per transfer; depends on hrt_pkg.
module hrt_step (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic [7:0]      data_byte,
   input  logic            last,
   output logic [1:0]      push_count,
   output hrt_pkg::rsp_type res0,
   output hrt_pkg::rsp_type res1
);
   import hrt_pkg::*;

   typedef enum logic [2:0] {
      PH_METHOD  = 3'd0,
      PH_URI     = 3'd1,
      PH_VERSION = 3'd2,
      PH_LINE    = 3'd3,
      PH_KEY     = 3'd4,
      PH_VALUE   = 3'd5
   } phase_type;

   typedef struct packed {
      logic       put;
      tag_type    tag;
      logic [7:0] data;
      logic       valid;
      logic       fend;
      phase_type  phase;
      logic       cr;
      logic [3:0] vlen;
      status_type outcome;
   } hnd_type;

   phase_type  phase_ff, phase_in;
   logic       cr_ff, cr_in;
   logic [3:0] vlen_ff, vlen_in;
   logic [7:0] hcnt_ff, hcnt_in;
   status_type outcome_ff, outcome_in;

   phase_type  phase_cr;
   logic [3:0] vlen_cr;
   tag_type    tag_cr;
   hnd_type    hnd;
   logic [1:0] count;
   rsp_type    r0, r1;

   function automatic logic [3:0] vinc(logic [3:0] v);
      return (v == VLEN_MAX) ? v : v + 4'd1;
   endfunction

   function automatic rsp_type mk(tag_type t, logic [7:0] d, logic v, logic e,
                                  logic [7:0] idx);
      rsp_type r;
      r.field_tag    = t;
      r.out_byte     = d;
      r.byte_valid   = v;
      r.field_end    = e;
      r.header_index = idx;
      r.status       = ST_PARSING;
      r.result_last  = 1'b0;
      return r;
   endfunction

   function automatic hnd_type handle(phase_type ph, logic [7:0] b, logic [3:0] vl);
      hnd_type h;
      h.put     = 1'b0;
      h.tag     = TAG_NONE;
      h.data    = CH_NUL;
      h.valid   = 1'b0;
      h.fend    = 1'b0;
      h.phase   = ph;
      h.cr      = 1'b0;
      h.vlen    = vl;
      h.outcome = ST_PARSING;
      case (ph)
         PH_METHOD, PH_URI: begin
            h.put = 1'b1;
            if (b == CH_NUL) begin
               h.outcome = ST_ERROR;
            end else if (b == CH_SPACE) begin
               h.tag   = (ph == PH_METHOD) ? TAG_METHOD : TAG_URI;
               h.fend  = 1'b1;
               h.phase = (ph == PH_METHOD) ? PH_URI : PH_VERSION;
            end else begin
               h.tag   = (ph == PH_METHOD) ? TAG_METHOD : TAG_URI;
               h.data  = b;
               h.valid = 1'b1;
            end
         end
         PH_VERSION, PH_VALUE: begin
            if (b == CH_NUL) begin
               h.put     = 1'b1;
               h.outcome = ST_ERROR;
            end else if (b == CH_CR) begin
               h.cr = 1'b1;
            end else begin
               h.put   = 1'b1;
               h.tag   = (ph == PH_VERSION) ? TAG_VERSION : TAG_VALUE;
               h.data  = b;
               h.valid = 1'b1;
               if (ph == PH_VERSION) begin
                  h.vlen = vinc(vl);
               end
            end
         end
         PH_LINE: begin
            if (b == CH_NUL) begin
               h.put     = 1'b1;
               h.outcome = ST_COMPLETE;
            end else if (b == CH_CR) begin
               h.cr = 1'b1;
            end else if (b == CH_COLON) begin
               h.put   = 1'b1;
               h.tag   = TAG_KEY;
               h.fend  = 1'b1;
               h.phase = PH_VALUE;
            end else begin
               h.put   = 1'b1;
               h.tag   = TAG_KEY;
               h.data  = b;
               h.valid = 1'b1;
               h.phase = PH_KEY;
            end
         end
         PH_KEY: begin
            h.put = 1'b1;
            if (b == CH_NUL) begin
               h.outcome = ST_ERROR;
            end else if (b == CH_COLON) begin
               h.tag   = TAG_KEY;
               h.fend  = 1'b1;
               h.phase = PH_VALUE;
            end else begin
               h.tag   = TAG_KEY;
               h.data  = b;
               h.valid = 1'b1;
            end
         end
         default: begin
            h.put     = 1'b1;
            h.outcome = ST_ERROR;
         end
      endcase
      return h;
   endfunction

   // A held CR that turns out to be content moves the parse position first.
   always_comb begin
      case (phase_ff)
         PH_VERSION: begin
            phase_cr = PH_VERSION;
            tag_cr   = TAG_VERSION;
         end
         PH_VALUE: begin
            phase_cr = PH_VALUE;
            tag_cr   = TAG_VALUE;
         end
         default: begin
            phase_cr = PH_KEY;
            tag_cr   = TAG_KEY;
         end
      endcase
      vlen_cr = (phase_ff == PH_VERSION) ? vinc(vlen_ff) : vlen_ff;
      hnd     = handle(cr_ff ? phase_cr : phase_ff, data_byte, cr_ff ? vlen_cr : vlen_ff);
   end

   always_comb begin
      count      = 2'd0;
      r0         = mk(TAG_NONE, CH_NUL, 1'b0, 1'b0, hcnt_ff);
      r1         = r0;
      phase_in   = phase_ff;
      cr_in      = cr_ff;
      vlen_in    = vlen_ff;
      hcnt_in    = hcnt_ff;
      outcome_in = outcome_ff;
      if (outcome_ff != ST_PARSING) begin
         count = 2'd1;
      end else if (cr_ff) begin
         cr_in = 1'b0;
         count = 2'd1;
         if (data_byte == CH_LF) begin
            case (phase_ff)
               PH_VERSION: begin
                  r0 = mk(TAG_VERSION, CH_NUL, 1'b0, 1'b1, hcnt_ff);
                  if (vlen_ff == VERSION_BYTES) begin
                     phase_in = PH_LINE;
                  end else begin
                     outcome_in = ST_ERROR;
                  end
               end
               PH_VALUE: begin
                  r0       = mk(TAG_VALUE, CH_NUL, 1'b0, 1'b1, hcnt_ff);
                  hcnt_in  = (hcnt_ff == HCNT_MAX) ? hcnt_ff : hcnt_ff + 8'd1;
                  phase_in = PH_LINE;
               end
               default: begin
                  outcome_in = ST_COMPLETE;
               end
            endcase
         end else begin
            r0       = mk(tag_cr, CH_CR, 1'b1, 1'b0, hcnt_ff);
            phase_in = phase_cr;
            vlen_in  = vlen_cr;
            if (data_byte == CH_NUL) begin
               outcome_in = ST_ERROR;
            end else begin
               phase_in   = hnd.phase;
               cr_in      = hnd.cr;
               vlen_in    = hnd.vlen;
               outcome_in = hnd.outcome;
               if (hnd.put) begin
                  count = 2'd2;
                  r1    = mk(hnd.tag, hnd.data, hnd.valid, hnd.fend, hcnt_ff);
               end
            end
         end
      end else begin
         phase_in   = hnd.phase;
         cr_in      = hnd.cr;
         vlen_in    = hnd.vlen;
         outcome_in = hnd.outcome;
         count      = hnd.put ? 2'd1 : 2'd0;
         r0         = mk(hnd.tag, hnd.data, hnd.valid, hnd.fend, hcnt_ff);
      end
      if (last) begin
         if (outcome_in == ST_PARSING) begin
            outcome_in = (phase_in == PH_LINE && !cr_in) ? ST_COMPLETE : ST_ERROR;
         end
         if (count == 2'd0) begin
            count = 2'd1;
         end
      end
      r0.status      = outcome_in;
      r1.status      = outcome_in;
      r0.result_last = (count == 2'd1);
      r1.result_last = 1'b1;
   end

   assign push_count = fire ? count : 2'd0;
   assign res0       = r0;
   assign res1       = r1;

   always_ff @(posedge clock) begin
      if (reset || (fire && last)) begin
         phase_ff   <= PH_METHOD;
         cr_ff      <= 1'b0;
         vlen_ff    <= 4'd0;
         hcnt_ff    <= 8'd0;
         outcome_ff <= ST_PARSING;
      end else if (fire) begin
         phase_ff   <= phase_in;
         cr_ff      <= cr_in;
         vlen_ff    <= vlen_in;
         hcnt_ff    <= hcnt_in;
         outcome_ff <= outcome_in;
      end
   end

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd2 |-> !res0.result_last && res1.result_last
                             && res0.status == res1.status)
      else $error("two-result transfer has inconsistent last or status");

   a_pair_first_is_cr: assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd2 |-> res0.byte_valid && res0.out_byte == CH_CR)
      else $error("first of two results is not a released CR");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire && last |-> push_count != 2'd0 && res0.status != ST_PARSING)
      else $error("final byte gave no closing result");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      fire && last |=> phase_ff == PH_METHOD && !cr_ff && hcnt_ff == 8'd0
                       && outcome_ff == ST_PARSING)
      else $error("parser did not restart after final byte");

endmodule

// File: rtl/hrt_rsp_fifo.sv
// Result queue of the HTTP request head tokenizer: takes up to two records
// per cycle and hands out one per transfer. Depends on hrt_pkg.
module hrt_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  hrt_pkg::rsp_type din0,
   input  hrt_pkg::rsp_type din1,
   output logic             room,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hrt_pkg::rsp_type dout
);
   import hrt_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(RSP_DEPTH - 2);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(RSP_DEPTH);

   rsp_type             entries_ff [RSP_DEPTH];
   logic [PTR_W-1:0]    wptr_ff, wptr_in;
   logic [PTR_W-1:0]    rptr_ff, rptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                pop;

   assign rsp_valid = (count_ff != '0);
   assign dout      = entries_ff[rptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= ROOM_MAX);

   always_comb begin
      wptr_in  = wptr_ff + PTR_W'(push_count);
      rptr_in  = rptr_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wptr_ff] <= din0;
      end
      if (push_count == 2'd2) begin
         entries_ff[wptr_ff + PTR_W'(1)] <= din1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("result queue overflow");

   a_push_with_room: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |-> room)
      else $error("results pushed without room");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd0 && !pop |=> $stable(count_ff))
      else $error("queue count changed without a push or transfer");

endmodule

// File: rtl/http_request_head_tokenizer.sv
// HTTP request head tokenizer, top level: input register, tokenizer step, result queue.
// An accepted byte is held in the input register; its results are written into the
// result queue and offered from its head.
// Throughput: one byte per cycle while the result queue has room; a byte that releases a held
// CR gives two results, which the output side takes one per transfer.
// Reset: synchronous, active high; clears the parse state and empties the queue.
// Depends on hrt_pkg, hrt_step and hrt_rsp_fifo.
module http_request_head_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_field_tag,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_field_end,
   output logic [7:0] rsp_header_index,
   output logic [1:0] rsp_status,
   output logic       rsp_result_last
);
   import hrt_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       accept;
   logic       fire;
   logic       room;
   logic [1:0] push_count;
   rsp_type    res0, res1, dout;

   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
   end

   hrt_step u_step (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .data_byte  (in_byte_ff),
      .last       (in_last_ff),
      .push_count (push_count),
      .res0       (res0),
      .res1       (res1)
   );

   hrt_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .din0       (res0),
      .din1       (res1),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .dout       (dout)
   );

   assign rsp_field_tag    = dout.field_tag;
   assign rsp_out_byte     = dout.out_byte;
   assign rsp_byte_valid   = dout.byte_valid;
   assign rsp_field_end    = dout.field_end;
   assign rsp_header_index = dout.header_index;
   assign rsp_status       = dout.status;
   assign rsp_result_last  = dout.result_last;

endmodule

// File: tb/sv/http_request_head_tokenizer_tb.sv
// Self-checking testbench for http_request_head_tokenizer: random request heads with idling on
// both channels, checked against a built-in prediction of the token stream.
// Depends on hrt_pkg and the http_request_head_tokenizer RTL.
`timescale 1ns / 1ps

module http_request_head_tokenizer_tb;
   import hrt_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int STIM_TARGET = 900;

   class head_token_checker;
      typedef enum logic [2:0] {
         PH_METHOD, PH_URI, PH_VERSION, PH_LINE, PH_KEY, PH_VALUE
      } phase_type;

      phase_type  phase;
      logic       cr_held;
      logic [3:0] version_len;
      logic [7:0] header_cnt;
      status_type outcome;
      rsp_type    step_tokens[$];
      rsp_type    expected_tokens[$];
      int         mismatches;

      function new();
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         phase = PH_METHOD;
         cr_held = 1'b0;
         version_len = '0;
         header_cnt = '0;
         outcome = ST_PARSING;
      endfunction

      function void emit(tag_type tag, logic [7:0] b, logic v, logic e);
         rsp_type t;
         if (step_tokens.size() < 2) begin
            t.field_tag = tag;
            t.out_byte = b;
            t.byte_valid = v;
            t.field_end = e;
            t.header_index = header_cnt;
            t.status = ST_PARSING;
            t.result_last = 1'b0;
            step_tokens.push_back(t);
         end
      endfunction

      function void text_error();
         outcome = ST_ERROR;
         emit(TAG_NONE, 8'h00, 1'b0, 1'b0);
      endfunction

      function void bump_version();
         if (version_len != VLEN_MAX) version_len++;
      endfunction

      function void key_byte(logic [7:0] b);
         if (b == CH_NUL) text_error();
         else if (b == CH_COLON) begin
            emit(TAG_KEY, 8'h00, 1'b0, 1'b1);
            phase = PH_VALUE;
         end else emit(TAG_KEY, b, 1'b1, 1'b0);
      endfunction

      function void handle_byte(logic [7:0] b);
         case (phase)
            PH_METHOD, PH_URI: begin
               if (b == CH_NUL) text_error();
               else if (b == CH_SPACE) begin
                  emit(phase == PH_METHOD ? TAG_METHOD : TAG_URI, 8'h00, 1'b0, 1'b1);
                  phase = (phase == PH_METHOD) ? PH_URI : PH_VERSION;
               end else emit(phase == PH_METHOD ? TAG_METHOD : TAG_URI, b, 1'b1, 1'b0);
            end
            PH_VERSION, PH_VALUE: begin
               if (b == CH_NUL) text_error();
               else if (b == CH_CR) cr_held = 1'b1;
               else begin
                  emit(phase == PH_VERSION ? TAG_VERSION : TAG_VALUE, b, 1'b1, 1'b0);
                  if (phase == PH_VERSION) bump_version();
               end
            end
            PH_LINE: begin
               if (b == CH_NUL) begin
                  outcome = ST_COMPLETE;
                  emit(TAG_NONE, 8'h00, 1'b0, 1'b0);
               end else if (b == CH_CR) cr_held = 1'b1;
               else begin
                  phase = PH_KEY;
                  key_byte(b);
               end
            end
            PH_KEY: key_byte(b);
            default: text_error();
         endcase
      endfunction

      function void parse_byte(logic [7:0] b);
         if (cr_held) begin
            cr_held = 1'b0;
            if (b == CH_LF) begin
               if (phase == PH_VERSION) begin
                  emit(TAG_VERSION, 8'h00, 1'b0, 1'b1);
                  if (version_len == VERSION_BYTES) phase = PH_LINE;
                  else outcome = ST_ERROR;
               end else if (phase == PH_VALUE) begin
                  emit(TAG_VALUE, 8'h00, 1'b0, 1'b1);
                  if (header_cnt != HCNT_MAX) header_cnt++;
                  phase = PH_LINE;
               end else begin
                  outcome = ST_COMPLETE;
                  emit(TAG_NONE, 8'h00, 1'b0, 1'b0);
               end
               return;
            end
            if (phase == PH_VERSION) begin
               emit(TAG_VERSION, CH_CR, 1'b1, 1'b0);
               bump_version();
            end else if (phase == PH_VALUE) emit(TAG_VALUE, CH_CR, 1'b1, 1'b0);
            else begin
               emit(TAG_KEY, CH_CR, 1'b1, 1'b0);
               phase = PH_KEY;
            end
            if (b == CH_NUL) begin
               outcome = ST_ERROR;
               return;
            end
         end
         handle_byte(b);
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         step_tokens.delete();
         if (outcome != ST_PARSING) emit(TAG_NONE, 8'h00, 1'b0, 1'b0);
         else parse_byte(b);
         if (last) begin
            if (outcome == ST_PARSING)
               outcome = (phase == PH_LINE && !cr_held) ? ST_COMPLETE : ST_ERROR;
            if (step_tokens.size() == 0) emit(TAG_NONE, 8'h00, 1'b0, 1'b0);
         end
         foreach (step_tokens[k]) begin
            step_tokens[k].status = outcome;
            step_tokens[k].result_last = (k == step_tokens.size() - 1);
            expected_tokens.push_back(step_tokens[k]);
         end
         if (last) restart();
      endfunction

      function string token_text(rsp_type t);
         return {$sformatf("tag=%0d byte=%02h valid=%0b end=%0b",
                           t.field_tag, t.out_byte, t.byte_valid, t.field_end),
                 $sformatf(" index=%0d status=%0d last=%0b",
                           t.header_index, t.status, t.result_last)};
      endfunction

      function void check_token(rsp_type got);
         rsp_type want;
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: %s", token_text(got));
            return;
         end
         want = expected_tokens.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch expected: %s", token_text(want));
               $display("         actual:   %s", token_text(got));
            end
         end
      endfunction
   endclass

   typedef struct {
      logic [7:0] b;
      logic       l;
   } head_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_field_tag;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_field_end;
   logic [7:0] rsp_header_index;
   logic [1:0] rsp_status;
   logic       rsp_result_last;
   logic       calm = 1'b0;
   int         stall_left = 0;
   int         cycles = 0;

   head_token_checker tokens = new();
   head_byte_type     stim[$];

   http_request_head_tokenizer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_field_tag(rsp_field_tag),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_field_end(rsp_field_end),
      .rsp_header_index(rsp_header_index),
      .rsp_status(rsp_status),
      .rsp_result_last(rsp_result_last)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL http_request_head_tokenizer");
         $finish;
      end
   end

   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (r < 65) rsp_stall <= 1'b0;
      else begin
         rsp_stall <= 1'b1;
         stall_left <= (r < 93) ? $urandom_range(0, 2) : $urandom_range(4, 24);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.field_tag = tag_type'(rsp_field_tag);
         got.out_byte = rsp_out_byte;
         got.byte_valid = rsp_byte_valid;
         got.field_end = rsp_field_end;
         got.header_index = rsp_header_index;
         got.status = status_type'(rsp_status);
         got.result_last = rsp_result_last;
         tokens.check_token(got);
      end
   end

   function automatic void push_byte(logic [7:0] b, logic l = 1'b0);
      head_byte_type item;
      item.b = b;
      item.l = l;
      stim.push_back(item);
   endfunction

   function automatic void push_text(string s);
      for (int k = 0; k < s.len(); k++) push_byte(s[k]);
   endfunction

   function automatic logic [7:0] content_byte(logic [7:0] x1, logic [7:0] x2);
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == x1 || b == x2);
      return b;
   endfunction

   function automatic logic [7:0] noisy_byte();
      if ($urandom_range(0, 99) < 50) begin
         case ($urandom_range(0, 4))
            0: return CH_NUL;
            1: return CH_SPACE;
            2: return CH_COLON;
            3: return CH_CR;
            default: return CH_LF;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Most requests are well formed with random content; the ending varies so that
   // completion, end of text, a held CR at line start and truncation all occur.
   function automatic void queue_request(bit saturate);
      logic [7:0] seq[$];
      int         r;
      int         n_hdr;
      r = $urandom_range(0, 99);
      if (r >= 85 && !saturate) begin
         repeat ($urandom_range(1, 12)) seq.push_back(noisy_byte());
      end else begin
         repeat ($urandom_range(1, 6)) seq.push_back(content_byte(CH_SPACE, CH_NUL));
         seq.push_back(CH_SPACE);
         repeat ($urandom_range(1, 10)) seq.push_back(content_byte(CH_SPACE, CH_NUL));
         seq.push_back(CH_SPACE);
         repeat (($urandom_range(0, 9) == 0 && !saturate) ? $urandom_range(0, 17) : 8)
            seq.push_back(content_byte(CH_LF, CH_NUL));
         seq.push_back(CH_CR);
         seq.push_back(CH_LF);
         n_hdr = saturate ? 257 : $urandom_range(0, 4);
         repeat (n_hdr) begin
            if (!saturate)
               repeat ($urandom_range(0, 6)) seq.push_back(content_byte(CH_COLON, CH_CR));
            seq.push_back(CH_COLON);
            if (!saturate)
               repeat ($urandom_range(0, 8)) seq.push_back(content_byte(CH_LF, CH_NUL));
            seq.push_back(CH_CR);
            seq.push_back(CH_LF);
         end
         r = $urandom_range(0, 99);
         if (saturate || r < 65) begin
            seq.push_back(CH_CR);
            seq.push_back(CH_LF);
         end else if (r < 78) begin
            seq.push_back(CH_NUL);
            repeat ($urandom_range(0, 3)) seq.push_back(noisy_byte());
         end else if (r < 90) begin
            seq.push_back(CH_CR);
            seq.push_back(noisy_byte());
         end else begin
            r = $urandom_range(1, seq.size());
            while (seq.size() > r) void'(seq.pop_back());
         end
      end
      foreach (seq[k]) push_byte(seq[k], k == seq.size() - 1);
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   initial begin
      int gap;
      push_text("G / HTTP/1.1");
      push_byte(CH_CR);
      push_byte(CH_LF);
      push_text("K:");
      push_byte(CH_CR);
      push_text("v");
      push_byte(CH_CR);
      push_byte(CH_LF);
      push_byte(CH_CR);
      push_byte(CH_LF, 1'b1);
      push_byte(CH_NUL);
      push_byte(8'hFF, 1'b1);
      while (stim.size() < 100) queue_request(1'b0);
      queue_request(1'b1);
      while (stim.size() < STIM_TARGET) queue_request(1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (stim[i]) begin
         calm <= ((i / 150) % 5 == 4);
         gap = idle_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data_byte <= stim[i].b;
         req_last <= stim[i].l;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         tokens.note_byte(stim[i].b, stim[i].l);
      end
      req_valid <= 1'b0;

      while (tokens.expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tokens.mismatches == 0 && tokens.expected_tokens.size() == 0)
         $display("PASS http_request_head_tokenizer");
      else
         $display("FAIL http_request_head_tokenizer");
      $finish;
   end

endmodule
